// File: design/ctg_pkg.sv
// Shared types, constants and helpers of the cone triangle generator.
`timescale 1ns / 1ps

package ctg_pkg;

	localparam int MAX_SEGMENTS    = 32;
	localparam int ROTATION_STAGES = 16;

	localparam int IDX_W   = 7;
	localparam int SEG_W   = $clog2(MAX_SEGMENTS + 1);
	localparam int VID_W   = $clog2(2 * MAX_SEGMENTS);
	localparam int PH_W    = 32;
	localparam int PH_FRAC = 31;
	localparam int CW      = 34;
	localparam int STG_W   = 5;

	localparam int DIV_STEPS   = VID_W + PH_FRAC;
	localparam int SQRT_STEPS  = 32;
	localparam int QDIV_STEPS  = 15;
	localparam int LANE_LAT    = DIV_STEPS + ROTATION_STAGES + 4;
	localparam int NRM_LAT     = 10 + SQRT_STEPS + QDIV_STEPS + 2;

	localparam logic [PH_W-1:0] TURN_HALF    = 32'h8000_0000;
	localparam logic [PH_W-1:0] TURN_QUARTER = 32'h4000_0000;
	localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
	localparam logic signed [CW-1:0] UNIT_POS     = 34'sd1073741824;
	localparam logic signed [CW-1:0] UNIT_NEG     = -34'sd1073741824;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	typedef enum logic [2:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_CENTER_Z    = 3'd2,
		REG_BASE_RADIUS = 3'd3,
		REG_CONE_HEIGHT = 3'd4,
		REG_SEGMENTS    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec_t;

	typedef struct packed {
		vec_t a;
		vec_t b;
		vec_t c;
	} tri_t;

	typedef struct packed {
		logic                 apex;
		logic                 flip;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cordic_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fff_ffff;
		else if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [31:0] clamp_unit(input logic signed [CW-1:0] v);
		if (v > UNIT_POS)
			return UNIT_POS[31:0];
		else if (v < UNIT_NEG)
			return UNIT_NEG[31:0];
		else
			return v[31:0];
	endfunction

endpackage

// File: design/ctg_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation cell.
`timescale 1ns / 1ps

module ctg_cordic_cell (
	input  logic                       clk,
	input  logic                       en,
	input  logic [ctg_pkg::STG_W-1:0]  stage,
	input  ctg_pkg::cordic_t           d_in,
	output ctg_pkg::cordic_t           d_out
);
	import ctg_pkg::*;

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	logic signed [CW-1:0] at;
	cordic_t              nxt;

	always_comb begin
		dx  = $signed(d_in.y) >>> stage;
		dy  = $signed(d_in.x) >>> stage;
		at  = $signed({{(CW-32){1'b0}}, ATAN_TAB[stage]});
		nxt = d_in;
		if (!d_in.z[CW-1]) begin
			nxt.x = d_in.x - dx;
			nxt.y = d_in.y + dy;
			nxt.z = d_in.z - at;
		end else begin
			nxt.x = d_in.x + dx;
			nxt.y = d_in.y - dy;
			nxt.z = d_in.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			d_out <= nxt;
	end

endmodule

// File: design/ctg_vertex_lane.sv
// Vertex lane: ring angle divider, CORDIC cell chain, radius scaling.
`timescale 1ns / 1ps

module ctg_vertex_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_in,
	input  logic [ctg_pkg::VID_W-1:0]  idx,
	input  logic                       apex,
	input  logic [ctg_pkg::SEG_W-1:0]  segc,
	input  logic [30:0]                radius,
	input  logic signed [31:0]         cx,
	input  logic signed [31:0]         cy,
	input  logic signed [31:0]         cz,
	input  logic signed [31:0]         hgt,
	output logic                       vld_out,
	output ctg_pkg::vec_t              vtx
);
	import ctg_pkg::*;

	logic [LANE_LAT-1:0] vld_q;

	logic [SEG_W-1:0] dv_rem_s [DIV_STEPS];
	logic [PH_W-1:0]  dv_quo_s [DIV_STEPS];
	logic [VID_W-1:0] dv_idx_s [DIV_STEPS];
	logic             dv_apx_s [DIV_STEPS];

	logic [PH_W-1:0] phase;
	logic [PH_W-1:0] ph_rot;
	logic [PH_W-1:0] ph_fold;
	cordic_t         cd_pre_s;
	cordic_t         cd_s [ROTATION_STAGES];

	logic signed [31:0] cos_s1;
	logic signed [31:0] sin_s1;
	logic               apx_s1;
	logic signed [63:0] px_s2;
	logic signed [63:0] py_s2;
	logic               apx_s2;
	logic signed [31:0] rads;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LANE_LAT-2:0], vld_in};
	end

	assign vld_out = vld_q[LANE_LAT-1];

	// restoring divide of idx * 2^31 by segc, one quotient bit per step
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int B = DIV_STEPS - 1 - k;
		logic [SEG_W-1:0] p_rem;
		logic [PH_W-1:0]  p_quo;
		logic [VID_W-1:0] p_idx;
		logic             p_apx;
		logic             dbit;
		logic [SEG_W:0]   trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign p_rem = '0;
			assign p_quo = '0;
			assign p_idx = idx;
			assign p_apx = apex;
		end else begin : g_next
			assign p_rem = dv_rem_s[k-1];
			assign p_quo = dv_quo_s[k-1];
			assign p_idx = dv_idx_s[k-1];
			assign p_apx = dv_apx_s[k-1];
		end

		if (B >= PH_FRAC) begin : g_bit
			assign dbit = p_idx[B-PH_FRAC];
		end else begin : g_zero
			assign dbit = 1'b0;
		end

		assign trial = {p_rem, dbit};
		assign ge    = trial >= {1'b0, segc};

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[k] <= ge ? SEG_W'(trial - {1'b0, segc}) : SEG_W'(trial);
				dv_quo_s[k] <= {p_quo[PH_W-2:0], ge};
				dv_idx_s[k] <= p_idx;
				dv_apx_s[k] <= p_apx;
			end
		end
	end

	// fold the angle into the right half plane
	assign phase   = dv_quo_s[DIV_STEPS-1];
	assign ph_rot  = phase + TURN_QUARTER;
	assign ph_fold = ph_rot[PH_W-1] ? (phase ^ TURN_HALF) : phase;

	always_ff @(posedge clk) begin
		if (en) begin
			cd_pre_s.apex <= dv_apx_s[DIV_STEPS-1];
			cd_pre_s.flip <= ph_rot[PH_W-1];
			cd_pre_s.x    <= CORDIC_START;
			cd_pre_s.y    <= '0;
			cd_pre_s.z    <= CW'($signed(ph_fold));
		end
	end

	for (genvar k = 0; k < ROTATION_STAGES; k++) begin : g_rot
		cordic_t c_in;
		if (k == 0) begin : g_first
			assign c_in = cd_pre_s;
		end else begin : g_next
			assign c_in = cd_s[k-1];
		end
		ctg_cordic_cell u_cell (
			.clk   (clk),
			.en    (en),
			.stage (STG_W'(k)),
			.d_in  (c_in),
			.d_out (cd_s[k])
		);
	end

	assign rads = $signed({1'b0, radius});

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s1 <= cd_s[ROTATION_STAGES-1].flip ?
				-clamp_unit(cd_s[ROTATION_STAGES-1].x) : clamp_unit(cd_s[ROTATION_STAGES-1].x);
			sin_s1 <= cd_s[ROTATION_STAGES-1].flip ?
				-clamp_unit(cd_s[ROTATION_STAGES-1].y) : clamp_unit(cd_s[ROTATION_STAGES-1].y);
			apx_s1 <= cd_s[ROTATION_STAGES-1].apex;

			px_s2  <= rads * cos_s1;
			py_s2  <= rads * sin_s1;
			apx_s2 <= apx_s1;

			if (apx_s2) begin
				vtx.x <= cx;
				vtx.y <= cy;
				vtx.z <= sat32(64'(cz) + 64'(hgt));
			end else begin
				vtx.x <= sat32(64'(cx) + ((px_s2 + 64'sd536870912) >>> 30));
				vtx.y <= sat32(64'(cy) + ((py_s2 + 64'sd536870912) >>> 30));
				vtx.z <= cz;
			end
		end
	end

endmodule

// File: design/ctg_normal.sv
// Unit normal of a triangle: cross product, normalize, square root, divide.
`timescale 1ns / 1ps

module ctg_normal (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_in,
	input  ctg_pkg::tri_t      t_in,
	output logic               vld_out,
	output ctg_pkg::tri_t      t_out,
	output logic signed [15:0] nx,
	output logic signed [15:0] ny,
	output logic signed [15:0] nz
);
	import ctg_pkg::*;

	typedef struct packed {
		logic             zero;
		logic [2:0]       ng;
		logic [2:0][30:0] mn;
	} aux_t;

	logic [NRM_LAT-1:0] vld_q;
	tri_t               tl_s [NRM_LAT];

	logic signed [32:0] df [6];
	logic [5:0]         neg_s1;
	logic [32:0]        mag_s1 [6];
	logic [32:0]        or_m;
	logic [1:0]         sh;
	logic signed [31:0] d2_s2 [6];
	logic signed [63:0] p_s3 [6];
	logic signed [63:0] cr [3];
	logic [2:0]         ng_s4;
	logic [62:0]        cm_s4 [3];
	logic [62:0]        or_s5;
	logic [2:0]         ng_s5;
	logic [62:0]        cm_s5 [3];
	logic [63:0]        orw;
	logic [2:0]         grp;
	logic [7:0]         byt;
	logic [2:0]         grp_s6;
	logic [7:0]         byt_s6;
	logic               zero_s6;
	logic [2:0]         ng_s6;
	logic [62:0]        cm_s6 [3];
	logic [2:0]         pos;
	logic [5:0]         lead_s7;
	logic               zero_s7;
	logic [2:0]         ng_s7;
	logic [62:0]        cm_s7 [3];
	aux_t               ax_s8;
	aux_t               ax_s9;
	logic [61:0]        sq_s9 [3];
	aux_t               ax_s10;
	logic [63:0]        sum_s10;

	logic [33:0] rt_rem_s [SQRT_STEPS];
	logic [31:0] rt_root_s [SQRT_STEPS];
	logic [63:0] rt_rad_s [SQRT_STEPS];
	aux_t        rt_ax_s [SQRT_STEPS];

	logic [45:0] num_s11 [3];
	logic [31:0] len_s11;
	aux_t        ax_s11;

	logic [31:0] qd_rem_s [QDIV_STEPS][3];
	logic [14:0] qd_q_s [QDIV_STEPS][3];
	logic [45:0] qd_num_s [QDIV_STEPS][3];
	logic [31:0] qd_len_s [QDIV_STEPS];
	aux_t        qd_ax_s [QDIV_STEPS];

	logic signed [15:0] nv [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[NRM_LAT-2:0], vld_in};
	end

	assign vld_out = vld_q[NRM_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			tl_s[0] <= t_in;
			for (int k = 1; k < NRM_LAT; k++)
				tl_s[k] <= tl_s[k-1];
		end
	end

	assign t_out = tl_s[NRM_LAT-1];

	// edge vectors u = B - A, v = C - B
	always_comb begin
		df[0] = 33'(t_in.b.x) - 33'(t_in.a.x);
		df[1] = 33'(t_in.b.y) - 33'(t_in.a.y);
		df[2] = 33'(t_in.b.z) - 33'(t_in.a.z);
		df[3] = 33'(t_in.c.x) - 33'(t_in.b.x);
		df[4] = 33'(t_in.c.y) - 33'(t_in.b.y);
		df[5] = 33'(t_in.c.z) - 33'(t_in.b.z);
	end

	always_comb begin
		or_m = '0;
		for (int i = 0; i < 6; i++)
			or_m = or_m | mag_s1[i];
		sh = or_m[32] ? 2'd2 : (or_m[31] ? 2'd1 : 2'd0);
	end

	always_comb begin
		cr[0] = p_s3[0] - p_s3[1];
		cr[1] = p_s3[2] - p_s3[3];
		cr[2] = p_s3[4] - p_s3[5];
	end

	// leading one of the OR of the cross magnitudes, byte then bit
	always_comb begin
		orw = {1'b0, or_s5};
		grp = '0;
		byt = '0;
		for (int g = 0; g < 8; g++) begin
			if (orw[g*8 +: 8] != 8'd0) begin
				grp = 3'(g);
				byt = orw[g*8 +: 8];
			end
		end
		pos = '0;
		for (int b = 0; b < 8; b++) begin
			if (byt_s6[b])
				pos = 3'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				neg_s1[i] <= df[i][32];
				mag_s1[i] <= df[i][32] ? 33'(-df[i]) : 33'(df[i]);
			end

			for (int i = 0; i < 6; i++)
				d2_s2[i] <= neg_s1[i] ? -$signed({1'b0, 31'(mag_s1[i] >> sh)})
				                      : $signed({1'b0, 31'(mag_s1[i] >> sh)});

			p_s3[0] <= d2_s2[1] * d2_s2[5];
			p_s3[1] <= d2_s2[2] * d2_s2[4];
			p_s3[2] <= d2_s2[2] * d2_s2[3];
			p_s3[3] <= d2_s2[0] * d2_s2[5];
			p_s3[4] <= d2_s2[0] * d2_s2[4];
			p_s3[5] <= d2_s2[1] * d2_s2[3];

			for (int i = 0; i < 3; i++) begin
				ng_s4[i] <= cr[i][63];
				cm_s4[i] <= cr[i][63] ? 63'(-cr[i]) : 63'(cr[i]);
			end

			or_s5 <= cm_s4[0] | cm_s4[1] | cm_s4[2];
			ng_s5 <= ng_s4;
			cm_s5 <= cm_s4;

			grp_s6  <= grp;
			byt_s6  <= byt;
			zero_s6 <= (or_s5 == '0);
			ng_s6   <= ng_s5;
			cm_s6   <= cm_s5;

			lead_s7 <= {grp_s6, pos};
			zero_s7 <= zero_s6;
			ng_s7   <= ng_s6;
			cm_s7   <= cm_s6;

			ax_s8.zero <= zero_s7;
			ax_s8.ng   <= ng_s7;
			for (int i = 0; i < 3; i++) begin
				if (lead_s7 >= 6'd30)
					ax_s8.mn[i] <= 31'(cm_s7[i] >> (lead_s7 - 6'd30));
				else
					ax_s8.mn[i] <= 31'(cm_s7[i] << (6'd30 - lead_s7));
			end

			ax_s9 <= ax_s8;
			for (int i = 0; i < 3; i++)
				sq_s9[i] <= 62'(ax_s8.mn[i]) * 62'(ax_s8.mn[i]);

			ax_s10  <= ax_s9;
			sum_s10 <= 64'(sq_s9[0]) + 64'(sq_s9[1]) + 64'(sq_s9[2]);
		end
	end

	// integer square root, one result bit per cell
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [33:0] p_rem;
		logic [31:0] p_root;
		logic [63:0] p_rad;
		aux_t        p_ax;
		logic [35:0] trial;
		logic [35:0] cand;
		logic        ge;

		if (k == 0) begin : g_first
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_rad  = sum_s10;
			assign p_ax   = ax_s10;
		end else begin : g_next
			assign p_rem  = rt_rem_s[k-1];
			assign p_root = rt_root_s[k-1];
			assign p_rad  = rt_rad_s[k-1];
			assign p_ax   = rt_ax_s[k-1];
		end

		assign trial = {p_rem, p_rad[63:62]};
		assign cand  = {2'b00, p_root, 2'b01};
		assign ge    = trial >= cand;

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[k]  <= ge ? 34'(trial - cand) : 34'(trial);
				rt_root_s[k] <= {p_root[30:0], ge};
				rt_rad_s[k]  <= {p_rad[61:0], 2'b00};
				rt_ax_s[k]   <= p_ax;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s11 <= rt_root_s[SQRT_STEPS-1];
			ax_s11  <= rt_ax_s[SQRT_STEPS-1];
			for (int i = 0; i < 3; i++)
				num_s11[i] <= {1'b0, rt_ax_s[SQRT_STEPS-1].mn[i], 14'd0} +
				              46'(rt_root_s[SQRT_STEPS-1] >> 1);
		end
	end

	// rounded quotient, at most 15 bits, one bit per cell
	for (genvar k = 0; k < QDIV_STEPS; k++) begin : g_qdiv
		localparam int B = QDIV_STEPS - 1 - k;
		logic [31:0] p_len;
		aux_t        p_ax;

		if (k == 0) begin : g_first
			assign p_len = len_s11;
			assign p_ax  = ax_s11;
		end else begin : g_next
			assign p_len = qd_len_s[k-1];
			assign p_ax  = qd_ax_s[k-1];
		end

		for (genvar i = 0; i < 3; i++) begin : g_comp
			logic [31:0] p_rem;
			logic [14:0] p_q;
			logic [45:0] p_num;
			logic [32:0] trial;
			logic        ge;

			if (k == 0) begin : g_first
				assign p_rem = 32'(num_s11[i][45:QDIV_STEPS]);
				assign p_q   = '0;
				assign p_num = num_s11[i];
			end else begin : g_next
				assign p_rem = qd_rem_s[k-1][i];
				assign p_q   = qd_q_s[k-1][i];
				assign p_num = qd_num_s[k-1][i];
			end

			assign trial = {p_rem, p_num[B]};
			assign ge    = trial >= {1'b0, p_len};

			always_ff @(posedge clk) begin
				if (en) begin
					qd_rem_s[k][i] <= ge ? 32'(trial - {1'b0, p_len}) : 32'(trial);
					qd_q_s[k][i]   <= {p_q[13:0], ge};
					qd_num_s[k][i] <= p_num;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				qd_len_s[k] <= p_len;
				qd_ax_s[k]  <= p_ax;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (qd_ax_s[QDIV_STEPS-1].zero)
					nv[i] <= '0;
				else if (qd_ax_s[QDIV_STEPS-1].ng[i])
					nv[i] <= -$signed({1'b0, qd_q_s[QDIV_STEPS-1][i]});
				else
					nv[i] <= $signed({1'b0, qd_q_s[QDIV_STEPS-1][i]});
			end
		end
	end

	assign nx = nv[0];
	assign ny = nv[1];
	assign nz = nv[2];

endmodule

// File: design/cone_triangle_generator.sv
// Top level: config registers, triangle index decode, vertex lanes, normal.
// Pipeline: decode register, vertex lanes (37 divider cells, pre-rotation register,
// 16 CORDIC cells, clamp, product and vertex registers), then the normal unit.
// Throughput: one triangle per cycle while output beats are taken; every stage is a register cell.
// The whole pipeline holds while an output beat waits un-taken.
// Reset (arst_n low) clears valid bits and loads the register defaults.
`timescale 1ns / 1ps

module cone_triangle_generator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [6:0] tri_index
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [335:0] m_tdata    // a_x a_y a_z b_x b_y b_z c_x c_y c_z (32 each), n_x n_y n_z (16 each)
);
	import ctg_pkg::*;

	localparam int NR_W = VID_W + 1;
	localparam int TT_W = VID_W + 2;

	logic signed [31:0] cx_q;
	logic signed [31:0] cy_q;
	logic signed [31:0] cz_q;
	logic [30:0]        rad_q;
	logic signed [31:0] hgt_q;
	logic [5:0]         seg_q;

	logic              en;
	logic [SEG_W-1:0]  segc;
	logic [NR_W-1:0]   nring;
	logic [TT_W-1:0]   ntot;
	logic [TT_W-1:0]   tt;
	logic [TT_W-1:0]   jj;
	logic [TT_W-1:0]   j1;
	logic              fan;
	logic [VID_W-1:0]  ia;
	logic [VID_W-1:0]  ib;
	logic [VID_W-1:0]  ic;

	logic              vld_s1;
	logic [VID_W-1:0]  ia_s1;
	logic [VID_W-1:0]  ib_s1;
	logic [VID_W-1:0]  ic_s1;
	logic              capx_s1;

	logic [2:0]        lv;
	vec_t              va;
	vec_t              vb;
	vec_t              vc;
	tri_t              tri_in;
	tri_t              tri_out;
	logic signed [15:0] n_x;
	logic signed [15:0] n_y;
	logic signed [15:0] n_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			cz_q  <= '0;
			rad_q <= 31'd65536;
			hgt_q <= 32'sd131072;
			seg_q <= 6'd12;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X:    cx_q  <= cfg_data;
				REG_CENTER_Y:    cy_q  <= cfg_data;
				REG_CENTER_Z:    cz_q  <= cfg_data;
				REG_BASE_RADIUS: rad_q <= cfg_data[30:0];
				REG_CONE_HEIGHT: hgt_q <= cfg_data;
				REG_SEGMENTS:    seg_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// base fan first, then side strip up to the apex
	always_comb begin
		if (seg_q < 6'd2)
			segc = SEG_W'(2);
		else if (seg_q > 6'(MAX_SEGMENTS))
			segc = SEG_W'(MAX_SEGMENTS);
		else
			segc = SEG_W'(seg_q);
		nring = {segc, 1'b0};
		ntot  = {segc, 2'b00} - TT_W'(2);
		tt    = TT_W'(s_tdata[IDX_W-1:0]);
		if (tt >= ntot)
			tt = ntot - TT_W'(1);
		fan = tt < (TT_W'(nring) - TT_W'(2));
		jj  = tt - (TT_W'(nring) - TT_W'(2));
		j1  = jj + TT_W'(1);
		if (fan) begin
			ia = '0;
			ib = VID_W'(tt + TT_W'(2));
			ic = VID_W'(tt + TT_W'(1));
		end else begin
			ia = VID_W'(jj);
			ib = (j1 == TT_W'(nring)) ? '0 : VID_W'(j1);
			ic = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ia_s1   <= ia;
			ib_s1   <= ib;
			ic_s1   <= ic;
			capx_s1 <= !fan;
		end
	end

	ctg_vertex_lane u_lane_a (
		.clk (clk), .arst_n (arst_n), .en (en), .vld_in (vld_s1),
		.idx (ia_s1), .apex (1'b0), .segc (segc), .radius (rad_q),
		.cx (cx_q), .cy (cy_q), .cz (cz_q), .hgt (hgt_q),
		.vld_out (lv[0]), .vtx (va)
	);

	ctg_vertex_lane u_lane_b (
		.clk (clk), .arst_n (arst_n), .en (en), .vld_in (vld_s1),
		.idx (ib_s1), .apex (1'b0), .segc (segc), .radius (rad_q),
		.cx (cx_q), .cy (cy_q), .cz (cz_q), .hgt (hgt_q),
		.vld_out (lv[1]), .vtx (vb)
	);

	ctg_vertex_lane u_lane_c (
		.clk (clk), .arst_n (arst_n), .en (en), .vld_in (vld_s1),
		.idx (ic_s1), .apex (capx_s1), .segc (segc), .radius (rad_q),
		.cx (cx_q), .cy (cy_q), .cz (cz_q), .hgt (hgt_q),
		.vld_out (lv[2]), .vtx (vc)
	);

	assign tri_in.a = va;
	assign tri_in.b = vb;
	assign tri_in.c = vc;

	ctg_normal u_normal (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (lv[0]),
		.t_in    (tri_in),
		.vld_out (m_tvalid),
		.t_out   (tri_out),
		.nx      (n_x),
		.ny      (n_y),
		.nz      (n_z)
	);

	assign m_tdata = {n_z, n_y, n_x,
	                  tri_out.c.z, tri_out.c.y, tri_out.c.x,
	                  tri_out.b.z, tri_out.b.y, tri_out.b.x,
	                  tri_out.a.z, tri_out.a.y, tri_out.a.x};

	a_decode_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ({1'b0, ia_s1} < nring && {1'b0, ib_s1} < nring && {1'b0, ic_s1} < nring))
		else $error("decoded vertex index past the ring");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		lv[0] == lv[1] && lv[1] == lv[2])
		else $error("vertex lanes out of step");

	a_normal_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (n_x >= -16'sd16384 && n_x <= 16'sd16384 &&
		              n_y >= -16'sd16384 && n_y <= 16'sd16384 &&
		              n_z >= -16'sd16384 && n_z <= 16'sd16384))
		else $error("normal component out of unit range");

endmodule
